@@ rtl/fpab_pkg.sv @@
// Shared types and constants of the framebuffer pixel alpha-blend engine.
package fpab_pkg;

    localparam int X_W       = 9;
    localparam int Y_W       = 9;
    localparam int DIM_W     = 10;
    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 20;  // x + y * width before the wrap
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 8'd1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 10'd480;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 10'd272;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_ALPHA = 2'd2,
        FUNC_BLEND = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRAP,
        ST_READ,
        ST_DATA,
        ST_MUL,
        ST_ACC,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CHAN_W-1:0] old_ch;
        logic [CHAN_W-1:0] new_ch;
        logic [CHAN_W-1:0] alpha;
        logic              div255;
    } t_mix_req;

endpackage

@@ rtl/framebuffer_pixel_alpha_blend_core.sv @@
// Top level of the framebuffer pixel engine: sequencer, clip check and address wrap.
//
// Usage:
//   Input stream (s_axis_*): one transaction names one pixel and an operation
//   (read, opaque write, alpha write with divide by 255, blend draw with shift
//   by 8). Output stream (m_axis_*): exactly one result transaction per input,
//   carrying the stored word for an inside read (zero otherwise) and the
//   inside flag. Configuration (i_cfg_*): index 0 is the active width, index 1
//   the active height; other indexes are dropped. Write them only while idle.
// Sequencing:
//   One pixel at a time; s_axis_tready is high only in the idle state.
//   Clipped pixel: address step, then done. Opaque write: stored in the wrap
//   step. Read or skipped/opaque alpha: wrap, read, data, then done. Blend: the
//   single mix unit handles one color channel at a time, and the single memory
//   port does the read, then the write. A pixel address past the memory size is
//   brought into range by compare-and-subtract steps in the wrap step.
// Reset: synchronous, active low; the sequencer goes idle, the output empties
//   and the active area returns to 480 x 272. The memory is not cleared.
// Stall: a finished result waits in the output register; the next pixel is
//   accepted meanwhile and holds in its done state until the register frees.
module framebuffer_pixel_alpha_blend_core
    import fpab_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // pos_x[8:0], pos_y[17:9], pixel_color[49:18]
    input  logic [1:0]           s_axis_tuser,  // func[1:0]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [COLOR_W-1:0]   m_axis_tdata,  // read_value[31:0]
    output logic                 m_axis_tuser,  // inside_res[0]
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int K_STEPS = (SUM_W > ADDR_W) ? (SUM_W - ADDR_W) : 0;
    localparam int CMP_W   = ADDR_W + K_STEPS + 1;
    localparam int KW      = $clog2(K_STEPS + 2);

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    t_state             r_state;
    t_state             n_state;
    t_func              r_func;
    logic [X_W-1:0]     r_x;
    logic [Y_W-1:0]     r_y;
    logic [COLOR_W-1:0] r_color;
    logic               r_inside;
    logic [CMP_W-1:0]   r_rem;
    logic [KW-1:0]      r_k;
    logic [1:0]         r_ch;
    logic [COLOR_W-1:0] r_old;
    logic [23:0]        r_mix;
    logic [COLOR_W-1:0] r_rdval;
    logic               r_ovalid;
    logic [COLOR_W-1:0] r_odata;
    logic               r_ouser;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;

    logic [CHAN_W-1:0]  w_alpha;
    logic [18:0]        w_prod;
    logic [SUM_W-1:0]   w_sum;
    logic [CMP_W-1:0]   w_dshift;
    logic               w_wrapped;
    logic               w_direct;
    logic               w_accept;
    logic               w_ram_we;
    logic [COLOR_W-1:0] w_ram_wdata;
    logic [COLOR_W-1:0] w_ram_rdata;
    logic [CHAN_W-1:0]  w_mix_out;
    t_mix_req           w_mix_req;

    assign w_alpha   = r_color[31:24];
    assign w_prod    = r_y * r_width;
    assign w_sum     = {11'b0, r_x} + {1'b0, w_prod};
    assign w_dshift  = DEPTH_C << r_k;
    assign w_wrapped = (r_rem < DEPTH_C);
    // no blend needed: store as given, skip, or hand back the read
    assign w_direct  = (r_func == FUNC_READ) || (w_alpha == ALPHA_OPAQUE) ||
                       ((r_func == FUNC_ALPHA) && (w_alpha == ALPHA_CLEAR));
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign o_cfg_ready   = 1'b1;

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_ADDR;
            ST_ADDR:  n_state = r_inside ? ST_WRAP : ST_DONE;
            ST_WRAP: begin
                if (w_wrapped) begin
                    // an opaque write needs no read of the old word
                    n_state = (r_func == FUNC_WRITE) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  n_state = ST_DATA;
            ST_DATA:  n_state = w_direct ? ST_DONE : ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = (r_ch == 2'd2) ? ST_WRITE : ST_MUL;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE:  if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs to the memory port, the mix unit and the input side.
    always_comb begin
        s_axis_tready = 1'b0;
        w_ram_we      = 1'b0;
        w_ram_wdata   = r_color;
        w_mix_req.old_ch = r_old[8*r_ch +: 8];
        w_mix_req.new_ch = r_color[8*r_ch +: 8];
        w_mix_req.alpha  = w_alpha;
        w_mix_req.div255 = (r_func == FUNC_ALPHA);
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_WRAP:  w_ram_we = w_wrapped && (r_func == FUNC_WRITE);
            ST_DATA:  w_ram_we = (r_func != FUNC_READ) && (w_alpha == ALPHA_OPAQUE);
            ST_WRITE: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = {ALPHA_OPAQUE, r_mix};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else begin
            r_state <= n_state;
            // Config registers: drop writes to unknown indexes.
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            // Output register: load on finish, empty on transaction.
            if (r_state == ST_DONE && n_state == ST_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= t_func'(s_axis_tuser);
            r_x      <= s_axis_tdata[8:0];
            r_y      <= s_axis_tdata[17:9];
            r_color  <= s_axis_tdata[49:18];
            r_inside <= ({1'b0, s_axis_tdata[8:0]} < r_width) &&
                        ({1'b0, s_axis_tdata[17:9]} < r_height);
            r_rdval  <= '0;
        end
        unique case (r_state)
            ST_ADDR: begin
                r_rem <= CMP_W'(w_sum);
                r_k   <= KW'(K_STEPS);
            end
            ST_WRAP: begin
                // Restoring remainder: one compare-and-subtract per cycle.
                if (!w_wrapped) begin
                    if (r_rem >= w_dshift) r_rem <= r_rem - w_dshift;
                    if (r_k != '0) r_k <= r_k - 1'b1;
                end
            end
            ST_DATA: begin
                r_old <= w_ram_rdata;
                r_ch  <= 2'd0;
                if (r_func == FUNC_READ) r_rdval <= w_ram_rdata;
            end
            ST_ACC: begin
                r_mix[8*r_ch +: 8] <= w_mix_out;
                r_ch               <= r_ch + 2'd1;
            end
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_odata <= r_rdval;
                    r_ouser <= r_inside;
                end
            end
            default: ;
        endcase
    end

    fpab_mix_unit u_mix (
        .i_clk  (i_clk),
        .i_req  (w_mix_req),
        .o_chan (w_mix_out)
    );

    fpab_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_addr  (r_rem[ADDR_W-1:0]),
        .i_we    (w_ram_we),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // An accepted pixel always leaves idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting a pixel");

    // The memory is written only for inside pixels and never by a read.
    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_inside && (r_func != FUNC_READ)))
        else $error("memory write for a clipped pixel or a read");

    // Writes happen only at an address already wrapped into the memory.
    a_write_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> w_wrapped)
        else $error("memory write before the address wrap finished");

    // A clipped result carries zero data.
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("clipped result with nonzero data");

endmodule

@@ rtl/fpab_mix_unit.sv @@
// Shared one-channel blend unit: weighted sum, then divide by 255 or shift by 8.
module fpab_mix_unit
    import fpab_pkg::*;
(
    input  logic              i_clk,
    input  t_mix_req          i_req,
    output logic [CHAN_W-1:0] o_chan
);

    logic [15:0]       w_p_new;
    logic [15:0]       w_p_old;
    logic [CHAN_W-1:0] w_inv;
    logic [16:0]       w_q;
    logic [15:0]       r_v;
    logic              r_div;

    assign w_inv   = ALPHA_OPAQUE - i_req.alpha;
    assign w_p_new = i_req.new_ch * i_req.alpha;
    assign w_p_old = i_req.old_ch * w_inv;

    always_ff @(posedge i_clk) begin
        r_v   <= w_p_new + w_p_old;
        r_div <= i_req.div255;
    end

    // Exact floor(v / 255) for v below 65280.
    assign w_q    = 17'(r_v) + 17'(r_v[15:8]) + 17'd1;
    assign o_chan = r_div ? w_q[15:8] : r_v[15:8];

endmodule

@@ rtl/fpab_frame_ram.sv @@
// Single-port framebuffer memory with registered read data.
module fpab_frame_ram
    import fpab_pkg::*;
#(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
) (
    input  logic               i_clk,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic               i_we,
    input  logic [COLOR_W-1:0] i_wdata,
    output logic [COLOR_W-1:0] o_rdata
);

    logic [COLOR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
